[hdl/sedm_pkg.sv]
// Package for the stereo echo delay mix unit: item types, configuration
// register codes and default sizes. No dependencies.
package sedm_pkg;

    localparam int MAX_DELAY_DEF      = 65536;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_GAIN     = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] DELAY_SAMPLES_RST = CFG_DATA_W'(22050);
    localparam logic [CFG_DATA_W-1:0] ECHO_GAIN_RST     = CFG_DATA_W'(2048);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       tail;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       clipped;
    } t_out_item;

endpackage

[hdl/sedm_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered
// read data. Read-first on a same-address write. No dependencies.
module sedm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/sedm_mix.sv]
// One channel of the echo mix: current sample plus delayed sample times
// gain, truncated toward zero and saturated to 16 bits. Uses sedm_pkg.
module sedm_mix #(
    parameter int GAIN_FRAC_BITS = sedm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic signed [sedm_pkg::SAMPLE_W-1:0]   i_cur,
    input  logic signed [sedm_pkg::SAMPLE_W-1:0]   i_old,
    input  logic        [sedm_pkg::CFG_DATA_W-1:0] i_gain,
    output logic signed [sedm_pkg::SAMPLE_W-1:0]   o_sample,
    output logic                                   o_clip
);
    import sedm_pkg::*;

    localparam int PROD_W = SAMPLE_W + CFG_DATA_W + 1;
    localparam int BASE_W = SAMPLE_W + GAIN_FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] quot;
    logic                    rnd;

    always_comb begin
        prod = $signed(i_old) * $signed({1'b0, i_gain});
        base = ACC_W'(i_cur) <<< GAIN_FRAC_BITS;
        acc  = base + prod;
        // floor shift, then step back up for negative values with a fraction
        rnd  = acc[ACC_W-1] && (acc[GAIN_FRAC_BITS-1:0] != '0);
        quot = (acc >>> GAIN_FRAC_BITS) + $signed(ACC_W'(rnd));
        if (quot > SAT_HI) begin
            o_sample = SAMPLE_W'(32767);
            o_clip   = 1'b1;
        end else if (quot < SAT_LO) begin
            o_sample = SAMPLE_W'(-32768);
            o_clip   = 1'b1;
        end else begin
            o_sample = quot[SAMPLE_W-1:0];
            o_clip   = 1'b0;
        end
    end

endmodule

[hdl/stereo_echo_delay_mix_unit.sv]
// Top level of the stereo echo delay mix: delay line, pointer and fill
// tracking, mix stage and result register. Uses sedm_pkg, sedm_ram, sedm_mix.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an accepted item passes the
// registered delay-line read and then the mix stage into the result register.
// Reset is synchronous; the delay line is not cleared, entries not yet written
// since reset are masked to silence by the pointer and a wrapped flag.
// A stalled result holds in the output register while the read stage still
// takes one more item; the input stalls only when both are full.
module stereo_echo_delay_mix_unit #(
    parameter int MAX_DELAY      = sedm_pkg::MAX_DELAY_DEF,
    parameter int GAIN_FRAC_BITS = sedm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  sedm_pkg::t_in_item                  i_in_item,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output sedm_pkg::t_out_item                 o_out_item,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sedm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sedm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sedm_pkg::*;

    localparam int PTR_W = $clog2(MAX_DELAY);
    localparam int DW    = (PTR_W + 1 > CFG_DATA_W) ? PTR_W + 1 : CFG_DATA_W;
    localparam logic [DW-1:0]    MAX_D   = DW'(MAX_DELAY);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_DELAY - 1);

    logic [CFG_DATA_W-1:0] r_delay_samples;
    logic [CFG_DATA_W-1:0] r_echo_gain;

    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] n_wp;
    logic             r_wrapped;

    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_cur_l;
    logic signed [SAMPLE_W-1:0] r_s1_cur_r;
    logic                       r_s1_zero_dly;
    logic                       r_s1_hit;

    logic      r_out_valid;
    t_out_item r_out_item;

    logic                       in_acc;
    logic                       out_ready;
    logic                       s1_move;
    logic signed [SAMPLE_W-1:0] cur_l;
    logic signed [SAMPLE_W-1:0] cur_r;
    logic [DW-1:0]              d_ext;
    logic [DW-1:0]              d_cl;
    logic [DW-1:0]              wp_ext;
    logic [DW-1:0]              rd_full;
    logic [PTR_W-1:0]           rd_addr;
    logic                       hit;
    logic [2*SAMPLE_W-1:0]      ram_rd;
    logic signed [SAMPLE_W-1:0] old_l;
    logic signed [SAMPLE_W-1:0] old_r;
    logic signed [SAMPLE_W-1:0] mix_l;
    logic signed [SAMPLE_W-1:0] mix_r;
    logic                       clip_l;
    logic                       clip_r;

    // handshakes
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && out_ready;
    assign o_in_stall  = r_s1_valid && !out_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // read address and fill check
    always_comb begin
        cur_l   = i_in_item.tail ? '0 : i_in_item.left_in;
        cur_r   = i_in_item.tail ? '0 : i_in_item.right_in;
        d_ext   = DW'(r_delay_samples);
        d_cl    = (d_ext > MAX_D) ? MAX_D : d_ext;
        wp_ext  = DW'(r_wp);
        rd_full = (wp_ext >= d_cl) ? (wp_ext - d_cl) : (wp_ext + MAX_D - d_cl);
        rd_addr = rd_full[PTR_W-1:0];
        // entries are written in order from zero, so before the first wrap
        // only those below the pointer hold data
        hit     = r_wrapped || (rd_addr < r_wp);
        n_wp    = (r_wp == PTR_TOP) ? '0 : r_wp + PTR_W'(1);
    end

    sedm_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_delay_line (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_wp),
        .i_wr_data ({cur_r, cur_l}),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd)
    );

    always_comb begin
        if (r_s1_zero_dly) begin
            old_l = r_s1_cur_l;
            old_r = r_s1_cur_r;
        end else if (r_s1_hit) begin
            old_l = ram_rd[SAMPLE_W-1:0];
            old_r = ram_rd[2*SAMPLE_W-1:SAMPLE_W];
        end else begin
            old_l = '0;
            old_r = '0;
        end
    end

    sedm_mix #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix_l (
        .i_cur    (r_s1_cur_l),
        .i_old    (old_l),
        .i_gain   (r_echo_gain),
        .o_sample (mix_l),
        .o_clip   (clip_l)
    );

    sedm_mix #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix_r (
        .i_cur    (r_s1_cur_r),
        .i_old    (old_r),
        .i_gain   (r_echo_gain),
        .o_sample (mix_r),
        .o_clip   (clip_r)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_samples <= DELAY_SAMPLES_RST;
            r_echo_gain     <= ECHO_GAIN_RST;
            r_wp            <= '0;
            r_wrapped       <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY_SAMPLES: r_delay_samples <= i_cfg_data;
                    CFG_ECHO_GAIN:     r_echo_gain     <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (in_acc) begin
                r_wp <= n_wp;
                if (r_wp == PTR_TOP) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cur_l    <= cur_l;
            r_s1_cur_r    <= cur_r;
            r_s1_zero_dly <= (r_delay_samples == '0);
            r_s1_hit      <= hit;
        end
        if (s1_move) begin
            r_out_item.left_out  <= mix_l;
            r_out_item.right_out <= mix_r;
            r_out_item.clipped   <= clip_l || clip_r;
        end
    end

endmodule

[verif/stereo_echo_delay_mix_unit_tb.sv]
// Testbench for the stereo echo delay mix unit: directed and random items checked
// against an in-bench model of the delay line and the saturating Q4.12 mix.
// Depends on sedm_pkg and stereo_echo_delay_mix_unit.
module stereo_echo_delay_mix_unit_tb;
    import sedm_pkg::*;

    localparam int DEPTH       = MAX_DELAY_DEF;
    localparam int FRAC        = GAIN_FRAC_BITS_DEF;
    localparam int IDLE_PCT    = 29;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 40;
    localparam int GAIN_ONE    = 1 << FRAC;

    // indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = '1;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_item;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // model state
    logic [31:0]           echo_line [DEPTH];
    int unsigned           wr_ptr;
    logic [CFG_DATA_W-1:0] delay_cfg;
    logic [CFG_DATA_W-1:0] gain_cfg;
    t_out_item             mix_expected [$];

    int  errors      = 0;
    int  idle_cycles = 0;
    bit  quiet       = 1'b0;

    stereo_echo_delay_mix_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // returns {clipped, sample}
    function automatic logic [16:0] mix_channel(input int cur, input int old);
        longint acc;
        longint r;
        logic   clip;
        acc  = longint'(cur) * GAIN_ONE + longint'(old) * longint'({48'd0, gain_cfg});
        r    = acc / GAIN_ONE;  // truncates toward zero
        clip = 1'b0;
        if (r > 32767) begin
            r    = 32767;
            clip = 1'b1;
        end else if (r < -32768) begin
            r    = -32768;
            clip = 1'b1;
        end
        return {clip, r[15:0]};
    endfunction

    task automatic predict_echo(input t_in_item it);
        int          cur_l;
        int          cur_r;
        int          old_l;
        int          old_r;
        int unsigned dly;
        int unsigned rd;
        logic [16:0] ml;
        logic [16:0] mr;
        t_out_item   res;
        cur_l = it.tail ? 0 : int'($signed(it.left_in));
        cur_r = it.tail ? 0 : int'($signed(it.right_in));
        dly   = (delay_cfg > DEPTH) ? DEPTH : delay_cfg;
        if (dly == 0) begin
            old_l = cur_l;
            old_r = cur_r;
        end else begin
            rd    = (wr_ptr + DEPTH - dly) % DEPTH;
            old_l = int'($signed(echo_line[rd][15:0]));
            old_r = int'($signed(echo_line[rd][31:16]));
        end
        ml            = mix_channel(cur_l, old_l);
        mr            = mix_channel(cur_r, old_r);
        res.left_out  = ml[15:0];
        res.right_out = mr[15:0];
        res.clipped   = ml[16] | mr[16];
        mix_expected.push_back(res);
        echo_line[wr_ptr] = {cur_r[15:0], cur_l[15:0]};
        wr_ptr = (wr_ptr + 1) % DEPTH;
    endtask

    function automatic t_in_item pair(input int l, input int r, input bit t);
        t_in_item it;
        it.left_in  = 16'(l);
        it.right_in = 16'(r);
        it.tail     = t;
        return it;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.left_in  = rand_sample();
        it.right_in = rand_sample();
        it.tail     = ($urandom_range(99) < 12);
        return it;
    endfunction

    // valid is left high after acceptance so back-to-back items go in without a gap
    task automatic send_sample(input t_in_item it);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_echo(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DELAY_SAMPLES) begin
            delay_cfg = val;
        end else if (idx == CFG_ECHO_GAIN) begin
            gain_cfg = val;
        end
    endtask

    // gain left at its reset value, so the echo shows the default scale
    task automatic test_reset_gain();
        write_reg(CFG_DELAY_SAMPLES, 16'd1);
        send_sample(pair(32767, -32768, 1'b0));
        send_sample(pair(-32768, 32767, 1'b0));
        send_sample(pair(1000, -1000, 1'b0));
        send_sample(pair(-3, 3, 1'b0));
    endtask

    // zero delay: the sample mixes with itself
    task automatic test_zero_delay();
        write_reg(CFG_DELAY_SAMPLES, 16'd0);
        write_reg(CFG_ECHO_GAIN, 16'(GAIN_ONE));
        send_sample(pair(32767, -32768, 1'b0));
        send_sample(pair(16383, -16384, 1'b0));
        send_sample(pair(-1, 1, 1'b0));
        send_sample(pair(5, 5, 1'b1));
    endtask

    task automatic test_gain_extremes();
        write_reg(CFG_DELAY_SAMPLES, 16'd1);
        write_reg(CFG_ECHO_GAIN, 16'hFFFF);
        send_sample(pair(32767, -32768, 1'b0));
        send_sample(pair(1, -1, 1'b0));
        send_sample(pair(0, 0, 1'b0));
        send_sample(pair(-32768, 32767, 1'b1));
        write_reg(CFG_ECHO_GAIN, 16'd0);
        send_sample(pair(100, -100, 1'b0));
        send_sample(pair(32767, -32768, 1'b0));
    endtask

    // tail items play the echo out and write silence into the line
    task automatic test_tail_flush();
        write_reg(CFG_DELAY_SAMPLES, 16'd2);
        write_reg(CFG_ECHO_GAIN, 16'(GAIN_ONE));
        send_sample(pair(1234, -4321, 1'b0));
        send_sample(pair(-32768, 32767, 1'b0));
        repeat (3) send_sample(pair(-7, 7, 1'b1));
    endtask

    task automatic test_unused_index();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_TOP, 16'h0000);
        send_sample(pair(30000, -30000, 1'b0));
        send_sample(pair(-5, 5, 1'b0));
        send_sample(pair(30000, -30000, 1'b0));
    endtask

    // delay changes between phases without clearing the line
    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_DELAY_SAMPLES, 16'd1);
                    write_reg(CFG_ECHO_GAIN, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_DELAY_SAMPLES, 16'hFFFF);
                    write_reg(CFG_ECHO_GAIN, 16'd0);
                end
                default: begin
                    write_reg(CFG_DELAY_SAMPLES,
                              ($urandom_range(3) != 0) ? 16'($urandom_range(64)) : 16'($urandom));
                    write_reg(CFG_ECHO_GAIN,
                              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192)));
                end
            endcase
            quiet = (ph == 3);
            repeat (50) send_sample(rand_item());
            quiet = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (mix_expected.size() == 0) begin
                if (errors < REPORT_MAX)
                    $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                errors++;
            end else begin
                want = mix_expected.pop_front();
                if (out_item.left_out !== want.left_out) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: left_out expected %0d actual %0d", $time,
                                 want.left_out, out_item.left_out);
                    errors++;
                end
                if (out_item.right_out !== want.right_out) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: right_out expected %0d actual %0d", $time,
                                 want.right_out, out_item.right_out);
                    errors++;
                end
                if (out_item.clipped !== want.clipped) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: clipped expected %b actual %b", $time,
                                 want.clipped, out_item.clipped);
                    errors++;
                end
            end
        end
    end

    // counts cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < DEPTH; k++) echo_line[k] = '0;
        wr_ptr    = 0;
        delay_cfg = DELAY_SAMPLES_RST;
        gain_cfg  = ECHO_GAIN_RST;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_gain();
        test_zero_delay();
        test_gain_extremes();
        test_tail_flush();
        test_unused_index();
        test_random_settings();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
